// File: sv/fupd_pkg.sv
// ----------------------------------------------------------------------------
// fupd_pkg: shared types and constants for the form pair decoder
// Result kinds, parser state codes, the queue entry and hex digit decode.
// ----------------------------------------------------------------------------
package fupd_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] TERM_MAX = 8'd13;

  typedef enum logic [2:0] {
    K_NAME_BYTE   = 3'd0,
    K_VALUE_BYTE  = 3'd1,
    K_NAME_END    = 3'd2,
    K_PAIR_END    = 3'd3,
    K_DATA_END    = 3'd4,
    K_VALUE_TRUNC = 3'd5,
    K_NAME_ERR    = 3'd6,
    K_BAD_ESCAPE  = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    PH_NAME  = 2'd0,
    PH_VALUE = 2'd1,
    PH_SKIP  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } esc_t;

  typedef enum logic [1:0] {
    CFG_NAME_LIMIT  = 2'd0,
    CFG_VALUE_LIMIT = 2'd1,
    CFG_LC_HEX      = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } result_t;

  // One queue entry: all results caused by one input byte.
  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } cmd_t;

  // Returns {valid, nibble}.
  function automatic logic [4:0] hex_digit(input logic [7:0] b, input logic lc_ok);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, b[3:0] + 4'd9};
    end else if (lc_ok && b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// File: sv/form_urlencoded_pair_decoder.sv
// ----------------------------------------------------------------------------
// form_urlencoded_pair_decoder: streaming name=value&name=value decoder
// Front parser, short command queue and output serializer.
// ----------------------------------------------------------------------------
// Takes one raw byte per transfer and emits decoded name/value bytes plus
// markers (name end, pair end, data end, value truncated, name error, bad
// escape); out_last flags the final result of each input byte. Input accepts
// one byte per cycle, back to back, as long as the 4-entry command queue has
// room; in_ready depends only on queue occupancy. The output side delivers
// one result per cycle while out_ready is high, so a byte that yields two
// results (terminators after a value or a partial name, truncation followed
// by a name byte, bad escape at a terminator) takes two output transfers and
// bytes that yield none take none; the queue absorbs the difference.
// Config registers: 0 name_limit (8b, reset 29), 1 value_limit (16b, reset
// 255), 2 lowercase_hex_ok (1b, reset 0); write them only while idle.
module form_urlencoded_pair_decoder import fupd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input byte stream
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  // decoded results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic        out_last,
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_cmd, q_head;

  // parser: classifies each byte, builds the results it causes
  fupd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  // decouples parser from output backpressure
  fupd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // one result per output transfer
  fupd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

// File: sv/fupd_front.sv
// ----------------------------------------------------------------------------
// fupd_front: byte classifier and parser state
// Holds config and parser state, turns one byte into a queue entry.
// ----------------------------------------------------------------------------
module fupd_front import fupd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  logic [7:0]  name_limit_r;
  logic [15:0] value_limit_r;
  logic        lc_hex_r;

  phase_t      phase_r, phase_nxt;
  esc_t        esc_r, esc_nxt;
  logic [3:0]  hi_r, hi_nxt;
  logic [15:0] len_r, len_nxt;

  logic        accept;
  logic        is_term;
  logic [7:0]  dec;
  logic [4:0]  hx;
  logic [1:0]  cnt;
  result_t     r0, r1;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_term  = in_byte <= TERM_MAX;
  assign dec      = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
  assign hx       = hex_digit(in_byte, lc_hex_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_limit_r  <= 8'd29;
      value_limit_r <= 16'd255;
      lc_hex_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NAME_LIMIT:  name_limit_r  <= cfg_wdata[7:0];
        CFG_VALUE_LIMIT: value_limit_r <= cfg_wdata;
        CFG_LC_HEX:      lc_hex_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    esc_nxt   = esc_r;
    hi_nxt    = hi_r;
    len_nxt   = len_r;
    cnt       = 2'd0;
    r0        = '{kind: K_DATA_END, data: 8'd0};
    r1        = '{kind: K_DATA_END, data: 8'd0};
    if (phase_r == PH_SKIP) begin
      if (is_term) begin
        cnt       = 2'd1;
        phase_nxt = PH_NAME;
        len_nxt   = 16'd0;
      end
    end else if (esc_r != ESC_NONE) begin
      if (hx[4]) begin
        if (esc_r == ESC_HIGH) begin
          hi_nxt  = hx[3:0];
          esc_nxt = ESC_LOW;
        end else begin
          cnt     = 2'd1;
          r0.kind = (phase_r == PH_VALUE) ? K_VALUE_BYTE : K_NAME_BYTE;
          r0.data = {hi_r, hx[3:0]};
          esc_nxt = ESC_NONE;
          hi_nxt  = 4'd0;
        end
      end else begin
        esc_nxt = ESC_NONE;
        hi_nxt  = 4'd0;
        r0.kind = K_BAD_ESCAPE;
        if (is_term) begin
          cnt       = 2'd2;
          phase_nxt = PH_NAME;
          len_nxt   = 16'd0;
        end else begin
          cnt       = 2'd1;
          phase_nxt = PH_SKIP;
        end
      end
    end else if (phase_r == PH_VALUE) begin
      if (is_term) begin
        cnt       = 2'd2;
        r0.kind   = K_PAIR_END;
        phase_nxt = PH_NAME;
        len_nxt   = 16'd0;
      end else if (in_byte == CH_AMP) begin
        cnt       = 2'd1;
        r0.kind   = K_PAIR_END;
        phase_nxt = PH_NAME;
        len_nxt   = 16'd0;
      end else if (len_r >= value_limit_r) begin
        // truncation closes the pair; this byte opens a new name
        r0.kind   = K_VALUE_TRUNC;
        phase_nxt = PH_NAME;
        len_nxt   = 16'd0;
        if (in_byte == CH_EQ) begin
          cnt       = 2'd2;
          r1.kind   = K_NAME_END;
          phase_nxt = PH_VALUE;
        end else if (name_limit_r == 8'd0) begin
          cnt       = 2'd2;
          r1.kind   = K_NAME_ERR;
          phase_nxt = PH_SKIP;
        end else begin
          len_nxt = 16'd1;
          if (in_byte == CH_PCT) begin
            cnt     = 2'd1;
            esc_nxt = ESC_HIGH;
          end else begin
            cnt     = 2'd2;
            r1.kind = K_NAME_BYTE;
            r1.data = dec;
          end
        end
      end else begin
        len_nxt = len_r + 16'd1;
        if (in_byte == CH_PCT) begin
          esc_nxt = ESC_HIGH;
        end else begin
          cnt     = 2'd1;
          r0.kind = K_VALUE_BYTE;
          r0.data = dec;
        end
      end
    end else begin
      // name phase
      if (is_term) begin
        phase_nxt = PH_NAME;
        len_nxt   = 16'd0;
        if (len_r != 16'd0) begin
          cnt     = 2'd2;
          r0.kind = K_NAME_ERR;
        end else begin
          cnt = 2'd1;
        end
      end else if (in_byte == CH_EQ) begin
        cnt       = 2'd1;
        r0.kind   = K_NAME_END;
        phase_nxt = PH_VALUE;
        len_nxt   = 16'd0;
      end else if (len_r >= {8'd0, name_limit_r}) begin
        cnt       = 2'd1;
        r0.kind   = K_NAME_ERR;
        phase_nxt = PH_SKIP;
      end else begin
        len_nxt = len_r + 16'd1;
        if (in_byte == CH_PCT) begin
          esc_nxt = ESC_HIGH;
        end else begin
          cnt     = 2'd1;
          r0.kind = K_NAME_BYTE;
          r0.data = dec;
        end
      end
    end
  end

  assign q_push = accept && (cnt != 2'd0);
  assign q_cmd  = '{two: (cnt == 2'd2), first: r0, second: r1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NAME;
      esc_r   <= ESC_NONE;
      hi_r    <= 4'd0;
      len_r   <= 16'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      esc_r   <= esc_nxt;
      hi_r    <= hi_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

// File: sv/fupd_queue.sv
// ----------------------------------------------------------------------------
// fupd_queue: short command queue between front and back
// Register file with read and write pointers and an occupancy count.
// ----------------------------------------------------------------------------
module fupd_queue import fupd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t           q_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   count_r, count_nxt;

  assign full  = count_r == (QAW+1)'(QDEPTH);
  assign empty = count_r == '0;
  assign head  = q_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule

// File: sv/fupd_back.sv
// ----------------------------------------------------------------------------
// fupd_back: result serializer
// Pops entries and drives one result per transfer through an output register.
// ----------------------------------------------------------------------------
module fupd_back import fupd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  cmd_t       q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r, out_res_nxt;
  logic    out_last_r, out_last_nxt;
  logic    sec_valid_r, sec_valid_nxt;
  result_t sec_r, sec_nxt;
  logic    load;

  assign load = !out_valid_r || out_ready;

  always_comb begin
    q_pop         = 1'b0;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    out_last_nxt  = out_last_r;
    sec_valid_nxt = sec_valid_r;
    sec_nxt       = sec_r;
    if (load) begin
      if (sec_valid_r) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = sec_r;
        out_last_nxt  = 1'b1;
        sec_valid_nxt = 1'b0;
      end else if (!q_empty) begin
        q_pop         = 1'b1;
        out_valid_nxt = 1'b1;
        out_res_nxt   = q_head.first;
        out_last_nxt  = !q_head.two;
        sec_valid_nxt = q_head.two;
        sec_nxt       = q_head.second;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sec_valid_r <= sec_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    out_last_r <= out_last_nxt;
    sec_r      <= sec_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_res_r.kind;
  assign out_byte  = out_res_r.data;
  assign out_last  = out_last_r;

endmodule
